FILE: hw/rtl/mrp_pkg.sv
// Shared types and constants of the response frame checker.
`default_nettype none

package mrp_pkg;

  // Frame bookkeeping constants.
  localparam logic [8:0]  PosMax        = 9'd511;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [9:0]  MaxFrameLen   = 10'd256;
  localparam logic [9:0]  WriteFrameLen = 10'd8;
  localparam logic [9:0]  ReadOverhead  = 10'd5;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_MULTI = 2'd2,
    KIND_NONE  = 2'd3
  } mrp_kind_e;

  typedef enum logic [2:0] {
    REG_KIND     = 3'd0,
    REG_MAX_WORD = 3'd1,
    REG_READ_FN  = 3'd2,
    REG_WRITE_FN = 3'd3,
    REG_MULTI_FN = 3'd4
  } mrp_reg_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_FRAME = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_DEV_EXC   = 3'd6
  } mrp_status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_frame;
  } mrp_byte_t;

  typedef struct packed {
    logic [2:0] reg_index;
    logic [6:0] wdata;
  } mrp_cfg_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    mrp_status_e status;
    logic [6:0]  exception_code;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [6:0]  word_count;
    logic        last;
  } mrp_result_t;

  typedef struct packed {
    mrp_kind_e  kind;
    logic [6:0] max_words;
    logic [6:0] read_fn;
    logic [6:0] write_fn;
    logic [6:0] multi_fn;
  } mrp_cfg_t;

  // Results produced by one byte: an optional data word, then an optional status.
  typedef struct packed {
    logic        first_vld;
    logic        second_vld;
    mrp_result_t first;
    mrp_result_t second;
  } mrp_emit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mrp_stream_if.sv
// Valid/ready channel interface with a typed payload.
`default_nettype none

interface mrp_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/modbus_response_parser.sv
// Top level of the response frame checker.
//
//   channel   dir   payload                       beat meaning
//   byte_i    in    byte_value, end_of_frame      one received frame byte
//   result_o  out   mrp_result_t                  data word or final status
//   cfg_i     in    reg_index, wdata              one register write
//
// A byte is held in the input register and processed combinationally into the
// result register, so one byte per cycle is taken while results drain.
// A byte that completes a data word on the last byte of a frame yields two
// results; the status waits in a second slot until the word beat is taken,
// and no byte is processed meanwhile.
// Reset restores the register defaults and an empty frame.
// A stalled result sink stops the input after one buffered byte.
`default_nettype none

module modbus_response_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  mrp_stream_if.sink          byte_i,
  mrp_stream_if.source        result_o,
  mrp_stream_if.sink          cfg_i
);
  import mrp_pkg::*;

  mrp_cfg_t  cfg;
  mrp_emit_t emit;
  logic      room;
  logic      fire;

  assign cfg_i.ready = 1'b1;

  mrp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_beat_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  mrp_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .in_data_i  (byte_i.data),
    .room_i     (room),
    .fire_o     (fire),
    .emit_o     (emit)
  );

  mrp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .emit_i      (emit),
    .room_o      (room),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (result_o.data)
  );

  // A data word that is not the last result is followed at once by its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.ready && !result_o.data.result_kind && !result_o.data.last
    |=> result_o.valid && result_o.data.result_kind)
    else $error("status beat did not follow a data word");

  // Word indexes stay below the configured capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.data.result_kind
    |-> result_o.data.word_index < cfg.max_words)
    else $error("data word index beyond max_words");

  // A final status always closes the results of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.result_kind |-> result_o.data.last)
    else $error("status beat without last");

  // Echoed write fields only appear with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.status != ST_OK
    |-> result_o.data.reg_address == 16'h0000 && result_o.data.reg_value == 16'h0000)
    else $error("write echo on a failed frame");

endmodule

`default_nettype wire

FILE: hw/rtl/mrp_cfg_regs.sv
// Configuration register file of the response frame checker.
`default_nettype none

module mrp_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_valid_i,
  input  mrp_pkg::mrp_cfg_beat_t wr_beat_i,
  output mrp_pkg::mrp_cfg_t      cfg_o
);
  import mrp_pkg::*;

  mrp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      // Writes to indexes beyond the register list are dropped.
      case (wr_beat_i.reg_index)
        REG_KIND:     cfg_d.kind     = mrp_kind_e'(wr_beat_i.wdata[1:0]);
        REG_MAX_WORD: cfg_d.max_words = wr_beat_i.wdata;
        REG_READ_FN:  cfg_d.read_fn  = wr_beat_i.wdata;
        REG_WRITE_FN: cfg_d.write_fn = wr_beat_i.wdata;
        REG_MULTI_FN: cfg_d.multi_fn = wr_beat_i.wdata;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind      <= KIND_READ;
      cfg_q.max_words <= 7'd127;
      cfg_q.read_fn   <= 7'd3;
      cfg_q.write_fn  <= 7'd6;
      cfg_q.multi_fn  <= 7'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mrp_frame.sv
// Input register, per-frame state and single-pass result computation.
`default_nettype none

module mrp_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrp_pkg::mrp_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrp_pkg::mrp_byte_t in_data_i,
  input  logic               room_i,
  output logic               fire_o,
  output mrp_pkg::mrp_emit_t emit_o
);
  import mrp_pkg::*;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic      in_vld_q;
  mrp_byte_t in_q;
  logic      accept;
  logic      fire;

  logic [8:0]  pos_q, pos_n;
  logic [15:0] crc_q, crc_n;
  logic [7:0]  fn_q, fn_n;
  logic [7:0]  cnt_q, cnt_n;
  logic [7:0]  hi_q, hi_n;
  logic [15:0] addr_q, addr_n;
  logic [15:0] val_q, val_n;
  logic [15:0] rcrc_q, rcrc_n;

  logic [7:0]  b;
  logic        eof;
  logic [9:0]  pos_ext;
  logic [9:0]  len;
  logic [9:0]  exp_len;
  logic        fn_match;
  logic        word_path;
  logic        word_emit;
  logic [7:0]  idx;
  mrp_result_t r_word;
  mrp_result_t r_stat;

  assign accept     = in_valid_i && in_ready_o;
  assign fire       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || room_i;
  assign fire_o     = fire;

  assign b       = in_q.byte_value;
  assign eof     = in_q.end_of_frame;
  assign pos_ext = {1'b0, pos_q};
  assign len     = pos_ext + 10'd1;

  // Header capture happens before anything else looks at the frame state.
  always_comb begin
    pos_n  = (pos_q < PosMax) ? pos_q + 9'd1 : pos_q;
    fn_n   = (pos_q == 9'd1) ? b : fn_q;
    cnt_n  = (pos_q == 9'd2) ? b : cnt_q;
    addr_n = addr_q;
    val_n  = val_q;
    if (pos_q == 9'd2) addr_n = {b, 8'h00};
    if (pos_q == 9'd3) addr_n = {addr_q[15:8], b};
    if (pos_q == 9'd4) val_n  = {b, 8'h00};
    if (pos_q == 9'd5) val_n  = {val_q[15:8], b};
  end

  assign exp_len = (cfg_i.kind == KIND_READ) ? ({2'b00, cnt_n} + ReadOverhead) : WriteFrameLen;

  always_comb begin
    crc_n  = crc_q;
    rcrc_n = rcrc_q;
    if (pos_ext + 10'd2 < exp_len) begin
      crc_n = crc_byte(crc_q, b);
    end else if (pos_ext + 10'd2 == exp_len) begin
      rcrc_n = {rcrc_q[15:8], b};
    end else if (pos_ext + 10'd1 == exp_len) begin
      rcrc_n = {b, rcrc_q[7:0]};
    end
  end

  always_comb begin
    unique case (cfg_i.kind)
      KIND_READ:  fn_match = (fn_n == {1'b0, cfg_i.read_fn});
      KIND_WRITE: fn_match = (fn_n == {1'b0, cfg_i.write_fn});
      KIND_MULTI: fn_match = (fn_n == {1'b0, cfg_i.multi_fn});
      default:    fn_match = 1'b0;
    endcase
  end

  // Data words start at byte 3; the word completes on each even position.
  assign word_path = (cfg_i.kind == KIND_READ) && (fn_n == {1'b0, cfg_i.read_fn})
                     && (pos_q >= 9'd3);
  assign idx       = pos_q[8:1] - 8'd2;
  assign word_emit = word_path && !pos_q[0] && (idx < {1'b0, cnt_n[7:1]})
                     && (idx < {1'b0, cfg_i.max_words});
  assign hi_n      = (word_path && pos_q[0]) ? b : hi_q;

  always_comb begin
    r_word             = '0;
    r_word.result_kind = 1'b0;
    r_word.word_value  = {hi_q, b};
    r_word.word_index  = idx[6:0];
    r_word.status      = ST_OK;
    r_word.last        = !eof;
  end

  always_comb begin
    r_stat             = '0;
    r_stat.result_kind = 1'b1;
    r_stat.last        = 1'b1;
    r_stat.status      = ST_OK;
    if (len < 10'd2) begin
      r_stat.status = ST_SHORT;
    end else if (fn_n[7]) begin
      // Exception response: byte 2 holds the code and the CRC is not checked.
      if (len < 10'd3) begin
        r_stat.status = ST_SHORT;
      end else if (cnt_n[7]) begin
        r_stat.status = ST_MALFORMED;
      end else begin
        r_stat.status         = ST_DEV_EXC;
        r_stat.exception_code = cnt_n[6:0];
      end
    end else if (!fn_match) begin
      r_stat.status = ST_BAD_FRAME;
    end else if (len < exp_len) begin
      r_stat.status = ST_SHORT;
    end else if (exp_len > MaxFrameLen) begin
      r_stat.status = ST_TOO_LONG;
    end else if (crc_n != rcrc_n) begin
      r_stat.status = ST_BAD_FRAME;
    end else if (cfg_i.kind == KIND_READ) begin
      if (cnt_n[0]) begin
        r_stat.status = ST_BAD_FRAME;
      end else begin
        r_stat.word_count = cnt_n[7:1];
        r_stat.status     = (cnt_n[7:1] > cfg_i.max_words) ? ST_TOO_MANY : ST_OK;
      end
    end else begin
      r_stat.reg_address = addr_n;
      r_stat.reg_value   = val_n;
    end
  end

  always_comb begin
    emit_o.first_vld  = word_emit || eof;
    emit_o.second_vld = word_emit && eof;
    emit_o.first      = word_emit ? r_word : r_stat;
    emit_o.second     = r_stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CrcInit;
      fn_q   <= '0;
      cnt_q  <= '0;
      hi_q   <= '0;
      addr_q <= '0;
      val_q  <= '0;
      rcrc_q <= '0;
    end else if (fire) begin
      if (eof) begin
        // The last byte closes the frame; the next byte opens a new one.
        pos_q  <= '0;
        crc_q  <= CrcInit;
        fn_q   <= '0;
        cnt_q  <= '0;
        hi_q   <= '0;
        addr_q <= '0;
        val_q  <= '0;
        rcrc_q <= '0;
      end else begin
        pos_q  <= pos_n;
        crc_q  <= crc_n;
        fn_q   <= fn_n;
        cnt_q  <= cnt_n;
        hi_q   <= hi_n;
        addr_q <= addr_n;
        val_q  <= val_n;
        rcrc_q <= rcrc_n;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mrp_out_stage.sv
// Result register with a second slot for the status that follows a data word.
`default_nettype none

module mrp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  mrp_pkg::mrp_emit_t   emit_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mrp_pkg::mrp_result_t out_data_o
);
  import mrp_pkg::*;

  logic        out_vld_q;
  mrp_result_t out_q;
  logic        ext_vld_q;
  mrp_result_t ext_q;
  logic        pop;

  assign pop    = out_vld_q && out_ready_i;
  assign room_o = (!out_vld_q || out_ready_i) && !ext_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      ext_vld_q <= 1'b0;
    end else if (fire_i && emit_i.first_vld) begin
      out_vld_q <= 1'b1;
      ext_vld_q <= emit_i.second_vld;
    end else if (pop) begin
      out_vld_q <= ext_vld_q;
      ext_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && emit_i.first_vld) begin
      out_q <= emit_i.first;
      ext_q <= emit_i.second;
    end else if (pop && ext_vld_q) begin
      out_q <= ext_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench of the response frame checker: streams bytes in, checks every beat out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrp_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef enum logic [1:0] {
    FILL_LIT,
    FILL_CRC_LO,
    FILL_CRC_HI
  } fill_e;

  typedef struct packed {
    logic [7:0]  value;
    logic        eof;
    fill_e       fill;
    logic        typed;
    mrp_status_e status;
  } stim_row_t;

  localparam logic [6:0] ResetMaxWords = 7'd127;
  localparam logic [6:0] ResetReadFn   = 7'd3;
  localparam logic [6:0] ResetWriteFn  = 7'd6;
  localparam logic [6:0] ResetMultiFn  = 7'd16;
  localparam int         PhaseCount    = 9;
  localparam int         PhaseBytes    = 16;
  localparam int         GiantFrameLen = 520;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;
  int   tx_idle_pct = 10;
  int   rx_idle_pct = 83;
  int   mismatch_count = 0;
  int   bytes_sent = 0;

  mrp_stream_if #(.data_t(mrp_byte_t))     byte_if ();
  mrp_stream_if #(.data_t(mrp_result_t))   res_if ();
  mrp_stream_if #(.data_t(mrp_cfg_beat_t)) cfg_if ();

  assign res_if.ready = sink_ready;

  modbus_response_parser i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .byte_i   (byte_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the registers and of the frame being parsed.
  mrp_cfg_t    cfg;
  logic [8:0]  rx_pos;
  logic [15:0] rx_crc;
  logic [7:0]  rx_fn;
  logic [7:0]  rx_count;
  logic [7:0]  rx_hi;
  logic [15:0] rx_addr;
  logic [15:0] rx_val;
  logic [15:0] rx_crc_field;
  mrp_result_t parsed_results [$];
  mrp_result_t want;
  mrp_result_t got;

  mrp_kind_e phase_kind [PhaseCount] = '{KIND_READ, KIND_WRITE, KIND_MULTI, KIND_READ,
                                         KIND_NONE, KIND_READ, KIND_WRITE, KIND_MULTI,
                                         KIND_READ};

  stim_row_t directed_rows [21] = '{
    // A lone byte is too short for anything.
    '{8'h00, 1'b1, FILL_LIT, 1'b1, ST_SHORT},
    // Exception flag without a code byte.
    '{8'h01, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h83, 1'b1, FILL_LIT, 1'b1, ST_SHORT},
    // Exception code with its top bit set.
    '{8'hFF, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h83, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h80, 1'b1, FILL_LIT, 1'b1, ST_MALFORMED},
    // Device exception with the largest code.
    '{8'h11, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h83, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h7F, 1'b1, FILL_LIT, 1'b1, ST_DEV_EXC},
    // Function code that is not the read code.
    '{8'h01, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h04, 1'b1, FILL_LIT, 1'b1, ST_BAD_FRAME},
    // Good read response with one all-ones word.
    '{8'h01, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h03, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h02, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'hFF, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'hFF, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, ST_OK},
    '{8'h00, 1'b1, FILL_CRC_HI, 1'b1, ST_OK},
    // Read response cut off right after its count byte.
    '{8'h01, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h03, 1'b0, FILL_LIT, 1'b0, ST_OK},
    '{8'h04, 1'b1, FILL_LIT, 1'b1, ST_SHORT}
  };

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame();
    rx_pos       = '0;
    rx_crc       = CrcInit;
    rx_fn        = '0;
    rx_count     = '0;
    rx_hi        = '0;
    rx_addr      = '0;
    rx_val       = '0;
    rx_crc_field = '0;
  endfunction

  // Works out the beats that one accepted byte causes and queues them.
  function automatic void parse_byte(logic [7:0] b, logic eof);
    int          pos;
    int          len;
    int          flen;
    int          idx;
    logic        fn_ok;
    mrp_result_t r;
    pos = int'(rx_pos);
    len = pos + 1;
    if (rx_pos < PosMax) rx_pos++;
    case (pos)
      1: rx_fn = b;
      2: begin
        rx_count = b;
        rx_addr  = {b, 8'h00};
      end
      3: rx_addr[7:0] = b;
      4: rx_val = {b, 8'h00};
      5: rx_val[7:0] = b;
      default: ;
    endcase
    flen = (cfg.kind == KIND_READ) ? int'(rx_count) + int'(ReadOverhead) : int'(WriteFrameLen);
    if (pos + 2 < flen) rx_crc = crc16_step(rx_crc, b);
    else if (pos + 2 == flen) rx_crc_field[7:0] = b;
    else if (pos + 1 == flen) rx_crc_field[15:8] = b;

    if (cfg.kind == KIND_READ && rx_fn == {1'b0, cfg.read_fn} && pos >= 3) begin
      if (pos % 2 == 1) begin
        rx_hi = b;
      end else begin
        idx = (pos - 4) / 2;
        if (idx < int'(rx_count[7:1]) && idx < int'(cfg.max_words)) begin
          r            = '0;
          r.word_value = {rx_hi, b};
          r.word_index = idx[6:0];
          r.last       = !eof;
          parsed_results.push_back(r);
        end
      end
    end

    if (eof) begin
      r             = '0;
      r.result_kind = 1'b1;
      r.last        = 1'b1;
      case (cfg.kind)
        KIND_READ:  fn_ok = (rx_fn == {1'b0, cfg.read_fn});
        KIND_WRITE: fn_ok = (rx_fn == {1'b0, cfg.write_fn});
        KIND_MULTI: fn_ok = (rx_fn == {1'b0, cfg.multi_fn});
        default:    fn_ok = 1'b0;
      endcase
      if (len < 2) begin
        r.status = ST_SHORT;
      end else if (rx_fn[7]) begin
        // Exception responses carry no CRC check.
        if (len < 3) begin
          r.status = ST_SHORT;
        end else if (rx_count[7]) begin
          r.status = ST_MALFORMED;
        end else begin
          r.status         = ST_DEV_EXC;
          r.exception_code = rx_count[6:0];
        end
      end else if (!fn_ok) begin
        r.status = ST_BAD_FRAME;
      end else if (len < flen) begin
        r.status = ST_SHORT;
      end else if (flen > int'(MaxFrameLen)) begin
        r.status = ST_TOO_LONG;
      end else if (rx_crc != rx_crc_field) begin
        r.status = ST_BAD_FRAME;
      end else if (cfg.kind == KIND_READ) begin
        if (rx_count[0]) begin
          r.status = ST_BAD_FRAME;
        end else begin
          r.word_count = rx_count[7:1];
          r.status     = (rx_count[7:1] > cfg.max_words) ? ST_TOO_MANY : ST_OK;
        end
      end else begin
        r.status      = ST_OK;
        r.reg_address = rx_addr;
        r.reg_value   = rx_val;
      end
      parsed_results.push_back(r);
      clear_frame();
    end
  endfunction

  task automatic send_byte(logic [7:0] v, logic eof);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.data  <= '{byte_value: v, end_of_frame: eof};
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
    parse_byte(v, eof);
  endtask

  task automatic set_reg(mrp_reg_e idx, logic [6:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: idx, wdata: v};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_KIND:     cfg.kind = mrp_kind_e'(v[1:0]);
      REG_MAX_WORD: cfg.max_words = v;
      REG_READ_FN:  cfg.read_fn = v;
      REG_WRITE_FN: cfg.write_fn = v;
      REG_MULTI_FN: cfg.multi_fn = v;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (parsed_results.size() != 0) @(posedge clk);
    // A trailing byte that yields no beat may still sit in the input register.
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [6:0] fn_code_for(int p);
    if (p == 5) return 7'h00;
    if (p == 6) return 7'h7F;
    return 7'($urandom_range(127));
  endfunction

  // Mostly well-formed frames for the current setting, mixed with exceptions and noise.
  task automatic random_frame(int pad_to);
    byte_q_t     fr;
    int          sel;
    int          mut;
    int          pick;
    int          count;
    logic [6:0]  code;
    logic [15:0] c;
    sel  = (pad_to > 0) ? 99 : int'($urandom_range(99));
    mut  = (pad_to > 0) ? 20 : int'($urandom_range(99));
    pick = $urandom_range(7);
    case (cfg.kind)
      KIND_WRITE: code = cfg.write_fn;
      KIND_MULTI: code = cfg.multi_fn;
      default:    code = cfg.read_fn;
    endcase
    if (pick == 0) code = 7'($urandom_range(127));
    fr.push_back(8'($urandom_range(255)));
    if (sel < 10) begin
      repeat ($urandom_range(9)) fr.push_back(8'($urandom_range(255)));
    end else if (sel < 22) begin
      fr.push_back({1'b1, code});
      if ($urandom_range(3) != 0) fr.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(2)) fr.push_back(8'($urandom_range(255)));
    end else begin
      fr.push_back({1'b0, code});
      if (cfg.kind == KIND_WRITE || cfg.kind == KIND_MULTI) begin
        count = 4;
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) count = $urandom_range(252, 255);
        else if (pick < 5) count = $urandom_range(255);
        else if (pick < 15) count = 2 * $urandom_range(6) + 1;
        else count = 2 * $urandom_range(10);
        fr.push_back(8'(count));
      end
      repeat (count) fr.push_back(8'($urandom_range(255)));
      c = CrcInit;
      foreach (fr[i]) c = crc16_step(c, fr[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (mut < 8) begin
        fr = fr[0:$urandom_range(fr.size() - 2)];
      end else if (mut < 16) begin
        pick = $urandom_range(fr.size() - 1);
        fr[pick] ^= 8'(1 << $urandom_range(7));
      end else if (mut < 24) begin
        repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom_range(255)));
      end
      while (fr.size() < pad_to) fr.push_back(8'($urandom_range(255)));
    end
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  always @(posedge clk) sink_ready <= ($urandom_range(99) >= rx_idle_pct);

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (parsed_results.size() == 0) begin
        $error("result beat with nothing outstanding: kind %0d status %0d",
               got.result_kind, got.status);
        mismatch_count++;
      end else begin
        want = parsed_results.pop_front();
        check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        check_field("word_value", want.word_value, got.word_value);
        check_field("word_index", 16'(want.word_index), 16'(got.word_index));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("exception_code", 16'(want.exception_code), 16'(got.exception_code));
        check_field("reg_address", want.reg_address, got.reg_address);
        check_field("reg_value", want.reg_value, got.reg_value);
        check_field("word_count", 16'(want.word_count), 16'(got.word_count));
        check_field("last", 16'(want.last), 16'(got.last));
      end
    end
  end

  initial begin
    int          phase_end;
    logic [6:0]  mw;
    logic [7:0]  v;
    logic [15:0] frame_crc;
    stim_row_t   row;
    byte_if.valid = 1'b0;
    byte_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    cfg = '{kind: KIND_READ, max_words: ResetMaxWords, read_fn: ResetReadFn,
            write_fn: ResetWriteFn, multi_fn: ResetMultiFn};
    clear_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames run on the register values after reset.
    frame_crc = CrcInit;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.fill)
        FILL_CRC_LO: v = frame_crc[7:0];
        FILL_CRC_HI: v = frame_crc[15:8];
        default: begin
          v         = row.value;
          frame_crc = crc16_step(frame_crc, v);
        end
      endcase
      send_byte(v, row.eof);
      if (row.typed) parsed_results[parsed_results.size() - 1].status = row.status;
      if (row.eof) frame_crc = CrcInit;
    end
    byte_if.valid <= 1'b0;

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      case (p / 3)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 83;
        end
        1: begin
          tx_idle_pct = 83;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (p)
        0, 8: mw = 7'd127;
        3: mw = 7'd0;
        default: mw = 7'($urandom_range(1, 10));
      endcase
      set_reg(REG_KIND, {5'($urandom_range(31)), phase_kind[p]});
      set_reg(REG_MAX_WORD, mw);
      set_reg(REG_READ_FN, fn_code_for(p));
      set_reg(REG_WRITE_FN, fn_code_for(p));
      set_reg(REG_MULTI_FN, fn_code_for(p));
      cfg_if.valid <= 1'b0;
      phase_end = bytes_sent + PhaseBytes;
      // One frame long enough to saturate the byte position.
      if (p == 6) random_frame(GiantFrameLen);
      while (bytes_sent < phase_end) random_frame(0);
      byte_if.valid <= 1'b0;
    end

    drain_results();
    if (mismatch_count == 0 && parsed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
